[rtl/gfne_pkg.sv]
// Shared types and constants for the grid four-neighbor expander.
// Depends on nothing; imported by gfne_ctrl, gfne_dp and the top level.
`default_nettype none

package gfne_pkg;

  // Fixed field widths of the request and result channels
  localparam int unsigned ACT_BITS      = 3;
  localparam int unsigned COORD_BITS    = 6;
  localparam int unsigned CELL_IN_BITS  = 8;
  localparam int unsigned CELL_OUT_BITS = 8;
  localparam int unsigned KIND_BITS     = 2;
  localparam int unsigned CNT_BITS      = 3;
  localparam int unsigned CFG_BITS      = 7;
  localparam int unsigned CFG_IDX_BITS  = 2;

  // Working widths: wide enough for any legal geometry parameter
  localparam int unsigned EXT_BITS = 16;
  localparam int unsigned LIM_BITS = 11;

  // Geometry defaults
  localparam int unsigned DEF_X_BITS    = 6;
  localparam int unsigned DEF_Y_BITS    = 6;
  localparam int unsigned DEF_CELL_BITS = 8;

  localparam logic [CFG_BITS-1:0] CFG_SIZE_RESET = 7'd64;
  localparam int unsigned CELL_OBSTACLE = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_HEIGHT = 2'd1;

  // Neighbor slots, in report order
  localparam int unsigned NB_COUNT    = 4;
  localparam int unsigned NB_IDX_BITS = 2;
  localparam logic [NB_IDX_BITS-1:0] NB_UP    = 2'd0;
  localparam logic [NB_IDX_BITS-1:0] NB_LEFT  = 2'd1;
  localparam logic [NB_IDX_BITS-1:0] NB_RIGHT = 2'd2;
  localparam logic [NB_IDX_BITS-1:0] NB_DOWN  = 2'd3;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_WRITE    = 3'd0,
    ACT_READ     = 3'd1,
    ACT_EXPAND   = 3'd2,
    ACT_CLR_FREE = 3'd3,
    ACT_CLR_OBST = 3'd4
  } action_t;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_ACK  = 2'd0,
    KIND_READ = 2'd1,
    KIND_NB   = 2'd2
  } kind_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_WR,
    ST_RD,
    ST_NB,
    ST_NBW,
    ST_SWEEP,
    ST_SWEEP_END,
    ST_EMIT
  } state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_in;   // capture the accepted request
    logic wr_cell;   // write the addressed cell (gated by bounds)
    logic rd_cell;   // read the addressed cell
    logic nb_rd;     // read the current neighbor slot, advance slot
    logic sweep_rd;  // read the sweep address, advance sweep
    logic init_wr;   // zero the cell at the sweep address, advance sweep
    logic emit;      // load the output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    action_t act;
    logic    in_grid;
    logic    out_free;
    logic    res_last;
    logic    swp_last;
    logic    nb_last;
  } st_t;

endpackage

`default_nettype wire

[rtl/gfne_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module gfne_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/gfne_ctrl.sv]
// Request sequencer of the grid four-neighbor expander.
// Depends on gfne_pkg; drives the datapath through cmd_t, watches st_t.
`default_nettype none

module gfne_ctrl
  import gfne_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  st_t  st,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (st.swp_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (st.act) inside
          ACT_WRITE:                  state_nxt = ST_WR;
          ACT_READ:                   state_nxt = ST_RD;
          ACT_EXPAND:                 state_nxt = st.in_grid ? ST_NB : ST_EMIT;
          ACT_CLR_FREE, ACT_CLR_OBST: state_nxt = ST_SWEEP;
          default:                    state_nxt = ST_EMIT;
        endcase
      end
      ST_WR: begin
        cmd.wr_cell = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_RD: begin
        cmd.rd_cell = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_NB: begin
        cmd.nb_rd = 1'b1;
        if (st.nb_last) begin
          state_nxt = ST_NBW;
        end
      end
      ST_NBW: begin
        state_nxt = ST_EMIT;
      end
      ST_SWEEP: begin
        cmd.sweep_rd = 1'b1;
        if (st.swp_last) begin
          state_nxt = ST_SWEEP_END;
        end
      end
      ST_SWEEP_END: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (st.res_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  // A result may only be loaded when the output register can take it
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.out_free)
    else $error("result loaded into a full output register");

endmodule

`default_nettype wire

[rtl/gfne_dp.sv]
// Datapath of the grid four-neighbor expander: request and size registers,
// grid RAM, neighbor capture, sweep counter, result formatting, output register.
// Depends on gfne_pkg and gfne_ram.
`default_nettype none

module gfne_dp
  import gfne_pkg::*;
#(
  parameter int unsigned X_BITS    = DEF_X_BITS,
  parameter int unsigned Y_BITS    = DEF_Y_BITS,
  parameter int unsigned CELL_BITS = DEF_CELL_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cmd_t                     cmd,
  output st_t                      st,
  // request fields
  input  logic [ACT_BITS-1:0]      in_action,
  input  logic [COORD_BITS-1:0]    in_pos_x,
  input  logic [COORD_BITS-1:0]    in_pos_y,
  input  logic [CELL_IN_BITS-1:0]  in_cell_in,
  // configuration writes
  input  logic                     cfg_wr,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]      cfg_data,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [KIND_BITS-1:0]     out_kind,
  output logic                     out_found,
  output logic [COORD_BITS-1:0]    out_nb_x,
  output logic [COORD_BITS-1:0]    out_nb_y,
  output logic [CELL_OUT_BITS-1:0] out_cell_out,
  output logic [CNT_BITS-1:0]      out_open_count,
  output logic                     out_out_of_bounds,
  output logic                     out_last
);

  localparam int unsigned ADDR_BITS = X_BITS + Y_BITS;
  localparam int unsigned DEPTH     = 1 << ADDR_BITS;
  localparam logic [LIM_BITS-1:0] COLS = LIM_BITS'(1 << X_BITS);
  localparam logic [LIM_BITS-1:0] ROWS = LIM_BITS'(1 << Y_BITS);
  localparam logic [CELL_BITS-1:0] OBST = CELL_BITS'(CELL_OBSTACLE);

  function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [COORD_BITS-1:0] x,
                                                     input logic [COORD_BITS-1:0] y);
    logic [EXT_BITS-1:0] xe;
    logic [EXT_BITS-1:0] ye;
    xe = EXT_BITS'(x);
    ye = EXT_BITS'(y);
    return {ye[Y_BITS-1:0], xe[X_BITS-1:0]};
  endfunction

  // coordinate below both the size register and the physical grid size
  function automatic logic below(input logic [LIM_BITS-1:0] c,
                                 input logic [CFG_BITS-1:0] lim,
                                 input logic [LIM_BITS-1:0] cap);
    return (c < LIM_BITS'(lim)) && (c < cap);
  endfunction

  // ---------------------------------------------------------------- registers
  logic [CFG_BITS-1:0]     gw_r, gh_r;
  action_t                 act_r;
  logic [COORD_BITS-1:0]   px_r, py_r;
  logic [CELL_IN_BITS-1:0] cin_r;
  logic [ADDR_BITS-1:0]    swp_r;
  logic [NB_IDX_BITS-1:0]  nb_idx_r;
  logic                    cap_v_r;
  logic [NB_IDX_BITS-1:0]  cap_idx_r;
  logic [CELL_BITS-1:0]    nb_val_r [NB_COUNT];
  logic [NB_COUNT-1:0]     done_r;
  logic                    wb_v_r;
  logic                    wb_inb_r;
  logic [ADDR_BITS-1:0]    wb_addr_r;
  logic                    out_valid_r;
  kind_t                   out_kind_r;
  logic                    out_found_r;
  logic [COORD_BITS-1:0]   out_x_r, out_y_r;
  logic [CELL_OUT_BITS-1:0] out_cell_r;
  logic [CNT_BITS-1:0]     out_cnt_r;
  logic                    out_oob_r;
  logic                    out_last_r;

  // ---------------------------------------------------------------- position
  logic                    in_grid;
  logic [ADDR_BITS-1:0]    pos_addr;
  logic [LIM_BITS-1:0]     px_l, py_l;

  assign px_l     = LIM_BITS'(px_r);
  assign py_l     = LIM_BITS'(py_r);
  assign in_grid  = below(px_l, gw_r, COLS) && below(py_l, gh_r, ROWS);
  assign pos_addr = cell_addr(px_r, py_r);

  // ---------------------------------------------------------------- neighbors
  logic [COORD_BITS-1:0] nbx [NB_COUNT];
  logic [COORD_BITS-1:0] nby [NB_COUNT];
  logic [ADDR_BITS-1:0]  nb_addr [NB_COUNT];
  logic [NB_COUNT-1:0]   nb_inb;
  logic [NB_COUNT-1:0]   open_m;
  logic [NB_COUNT-1:0]   pend_m;
  logic [NB_IDX_BITS-1:0] first_idx;
  logic [NB_COUNT-1:0]   first_oh;
  logic [CNT_BITS-1:0]   open_cnt;

  always_comb begin
    nbx[NB_UP]    = px_r;        nby[NB_UP]    = py_r - 1'b1;
    nbx[NB_LEFT]  = px_r - 1'b1; nby[NB_LEFT]  = py_r;
    nbx[NB_RIGHT] = px_r + 1'b1; nby[NB_RIGHT] = py_r;
    nbx[NB_DOWN]  = px_r;        nby[NB_DOWN]  = py_r + 1'b1;
    nb_inb[NB_UP]    = (py_r != '0);
    nb_inb[NB_LEFT]  = (px_r != '0);
    nb_inb[NB_RIGHT] = below(px_l + 1'b1, gw_r, COLS);
    nb_inb[NB_DOWN]  = below(py_l + 1'b1, gh_r, ROWS);
    for (int i = 0; i < NB_COUNT; i++) begin
      nb_addr[i] = cell_addr(nbx[i], nby[i]);
      open_m[i]  = nb_inb[i] && (nb_val_r[i] != OBST);
    end
  end

  assign pend_m = open_m & ~done_r;

  always_comb begin
    first_idx = '0;
    open_cnt  = '0;
    for (int i = NB_COUNT - 1; i >= 0; i--) begin
      if (pend_m[i]) begin
        first_idx = NB_IDX_BITS'(i);
      end
    end
    for (int i = 0; i < NB_COUNT; i++) begin
      open_cnt = open_cnt + CNT_BITS'(open_m[i]);
    end
    first_oh = '0;
    first_oh[first_idx] = 1'b1;
  end

  // ---------------------------------------------------------------- grid RAM
  logic                    ram_we, ram_re;
  logic [ADDR_BITS-1:0]    ram_waddr, ram_raddr;
  logic [CELL_BITS-1:0]    ram_wdata, ram_q;
  logic [EXT_BITS-1:0]     cin_ext, q_ext, nbv_ext;
  logic                    wb_hit;
  logic                    swp_inb;

  assign cin_ext = EXT_BITS'(cin_r);
  assign q_ext   = EXT_BITS'(ram_q);
  assign nbv_ext = EXT_BITS'(nb_val_r[first_idx]);

  // clear-free zeros open cells, clear-obstacles zeros obstacle cells
  assign wb_hit = wb_v_r && wb_inb_r &&
                  ((act_r == ACT_CLR_FREE) ? (ram_q != OBST) : (ram_q == OBST));

  assign swp_inb = (LIM_BITS'(swp_r[X_BITS-1:0]) < LIM_BITS'(gw_r)) &&
                   (LIM_BITS'(swp_r[ADDR_BITS-1:X_BITS]) < LIM_BITS'(gh_r));

  always_comb begin
    ram_we    = cmd.init_wr || (cmd.wr_cell && in_grid) || wb_hit;
    ram_waddr = wb_addr_r;
    ram_wdata = '0;
    if (cmd.init_wr) begin
      ram_waddr = swp_r;
    end else if (cmd.wr_cell) begin
      ram_waddr = pos_addr;
      ram_wdata = cin_ext[CELL_BITS-1:0];
    end
    ram_re    = cmd.rd_cell || cmd.nb_rd || cmd.sweep_rd;
    ram_raddr = pos_addr;
    if (cmd.nb_rd) begin
      ram_raddr = nb_addr[nb_idx_r];
    end else if (cmd.sweep_rd) begin
      ram_raddr = swp_r;
    end
  end

  gfne_ram #(
    .WIDTH (CELL_BITS),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // ---------------------------------------------------------------- result
  kind_t                    res_kind;
  logic                     res_found;
  logic [COORD_BITS-1:0]    res_x, res_y;
  logic [CELL_OUT_BITS-1:0] res_cell;
  logic [CNT_BITS-1:0]      res_cnt;
  logic                     res_oob;
  logic                     res_last;
  logic                     out_free;

  always_comb begin
    res_kind  = KIND_ACK;
    res_found = 1'b0;
    res_x     = '0;
    res_y     = '0;
    res_cell  = '0;
    res_cnt   = '0;
    res_oob   = 1'b0;
    res_last  = 1'b1;
    unique case (act_r)
      ACT_WRITE: begin
        res_oob = !in_grid;
      end
      ACT_READ: begin
        res_kind = KIND_READ;
        res_x    = px_r;
        res_y    = py_r;
        res_cell = in_grid ? q_ext[CELL_OUT_BITS-1:0] : '0;
        res_oob  = !in_grid;
      end
      ACT_EXPAND: begin
        res_kind = KIND_NB;
        res_oob  = !in_grid;
        if (in_grid && (open_m != '0)) begin
          res_found = 1'b1;
          res_x     = nbx[first_idx];
          res_y     = nby[first_idx];
          res_cell  = nbv_ext[CELL_OUT_BITS-1:0];
          res_cnt   = open_cnt;
          res_last  = ((pend_m & (pend_m - 1'b1)) == '0);
        end
      end
      default: begin
      end
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r        <= CFG_SIZE_RESET;
      gh_r        <= CFG_SIZE_RESET;
      swp_r       <= '0;
      nb_idx_r    <= '0;
      cap_v_r     <= 1'b0;
      wb_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          CFG_GRID_WIDTH:  gw_r <= cfg_data;
          CFG_GRID_HEIGHT: gh_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.init_wr || cmd.sweep_rd) begin
        swp_r <= swp_r + 1'b1;
      end
      if (cmd.nb_rd) begin
        nb_idx_r <= nb_idx_r + 1'b1;
      end
      cap_v_r <= cmd.nb_rd;
      wb_v_r  <= cmd.sweep_rd;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload regs
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      act_r  <= action_t'(in_action);
      px_r   <= in_pos_x;
      py_r   <= in_pos_y;
      cin_r  <= in_cell_in;
      done_r <= '0;
    end else if (cmd.emit) begin
      done_r <= done_r | first_oh;
    end
    cap_idx_r <= nb_idx_r;
    if (cap_v_r) begin
      nb_val_r[cap_idx_r] <= ram_q;
    end
    wb_addr_r <= swp_r;
    wb_inb_r  <= swp_inb;
    if (cmd.emit) begin
      out_kind_r  <= res_kind;
      out_found_r <= res_found;
      out_x_r     <= res_x;
      out_y_r     <= res_y;
      out_cell_r  <= res_cell;
      out_cnt_r   <= res_cnt;
      out_oob_r   <= res_oob;
      out_last_r  <= res_last;
    end
  end

  assign st.act      = act_r;
  assign st.in_grid  = in_grid;
  assign st.out_free = out_free;
  assign st.res_last = res_last;
  assign st.swp_last = &swp_r;
  assign st.nb_last  = &nb_idx_r;

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_found         = out_found_r;
  assign out_nb_x          = out_x_r;
  assign out_nb_y          = out_y_r;
  assign out_cell_out      = out_cell_r;
  assign out_open_count    = out_cnt_r;
  assign out_out_of_bounds = out_oob_r;
  assign out_last          = out_last_r;

  // ---------------------------------------------------------------- checks
  a_found_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_found_r |->
      out_kind_r == KIND_NB && !out_oob_r && out_cnt_r != '0)
    else $error("neighbor report with inconsistent fields");

  a_wport_free: assert property (@(posedge clk) disable iff (!rst_n)
    wb_v_r |-> !cmd.init_wr && !cmd.wr_cell)
    else $error("sweep write-back collides with another RAM write");

  a_emit_settled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !cap_v_r && !wb_v_r)
    else $error("result formed before RAM data settled");

endmodule

`default_nettype wire

[rtl/grid_four_neighbor_expander.sv]
// Top level of the grid four-neighbor expander: occupancy grid store with
// write, read, expand and clear requests. Depends on gfne_pkg, gfne_ctrl, gfne_dp.
//
// Usage:
//   Request channel (in_*): in_valid with in_stall driven by the block. A request
//   is taken on a clock edge with in_valid high and in_stall low. One request is
//   worked on at a time; in_stall stays high until its last result is loaded and
//   drops the cycle after.
//   Result channel (out_*): out_valid with out_stall from the receiver. A result
//   sits in an output register and holds while out_stall is high; the block takes
//   the next request while that result still waits.
//   Config channel (cfg_*): cfg_ready is always high; index 0 sets grid_width,
//   index 1 grid_height, other indexes are dropped. Write only while idle.
// From acceptance to the result register: write and read pass decode and their access
// state; expand reads the four neighbor cells in turn through the one read port of the
// grid RAM, then loads one report per open neighbor, or a single one if none is open;
// out-of-bounds expand and unused codes go from decode straight to emit; clears sweep
// every cell address, one cell per cycle through the grid RAM. A stalled receiver delays each load.
// Reset: a clearing pass zeros all 2^(X_BITS+Y_BITS) cells with in_stall high; sizes
// reset to 64.
`default_nettype none

module grid_four_neighbor_expander
  import gfne_pkg::*;
#(
  parameter int unsigned X_BITS    = DEF_X_BITS,
  parameter int unsigned Y_BITS    = DEF_Y_BITS,
  parameter int unsigned CELL_BITS = DEF_CELL_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // requests
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ACT_BITS-1:0]      in_action,
  input  logic [COORD_BITS-1:0]    in_pos_x,
  input  logic [COORD_BITS-1:0]    in_pos_y,
  input  logic [CELL_IN_BITS-1:0]  in_cell_in,
  // results
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [KIND_BITS-1:0]     out_kind,
  output logic                     out_found,
  output logic [COORD_BITS-1:0]    out_nb_x,
  output logic [COORD_BITS-1:0]    out_nb_y,
  output logic [CELL_OUT_BITS-1:0] out_cell_out,
  output logic [CNT_BITS-1:0]      out_open_count,
  output logic                     out_out_of_bounds,
  output logic                     out_last,
  // configuration
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_BITS-1:0]      cfg_data
);

  cmd_t cmd;
  st_t  st;

  // size registers take a write on any cycle
  assign cfg_ready = 1'b1;

  gfne_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  gfne_dp #(
    .X_BITS    (X_BITS),
    .Y_BITS    (Y_BITS),
    .CELL_BITS (CELL_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_action         (in_action),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_cell_in        (in_cell_in),
    .cfg_wr            (cfg_valid && cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_found         (out_found),
    .out_nb_x          (out_nb_x),
    .out_nb_y          (out_nb_y),
    .out_cell_out      (out_cell_out),
    .out_open_count    (out_open_count),
    .out_out_of_bounds (out_out_of_bounds),
    .out_last          (out_last)
  );

endmodule

`default_nettype wire
